### design/graph_adjacency_builder_assert.svh
// Assertion macros used by the adjacency builder top level.
`ifndef GRAPH_ADJACENCY_BUILDER_ASSERT_SVH
`define GRAPH_ADJACENCY_BUILDER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GAB_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define GAB_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### design/gab_pkg.sv
// Types and constants of the graph adjacency builder.
`timescale 1ns / 1ps
`default_nettype none
package gab_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_LIST_FULL = 2'd2;
    localparam logic [1:0] STATUS_NODE_FULL = 2'd3;

    localparam logic [19:0] EDGE_MAX = 20'hFFFFF;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] node_id;
        logic        one_way;
        logic [15:0] query_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] node_index;
        logic [1:0]  edges_added;
        logic [19:0] total_edges;
        logic [3:0]  succ_count;
        logic [15:0] succ_index;
        logic        last;
    } out_t;

    typedef struct packed {
        logic done;
        logic hit;
    } search_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } search_state_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_DISPATCH,
        M_SEARCH,
        M_ECNT,
        M_ECNTW,
        M_ESCAN,
        M_ECMP,
        M_QCNT,
        M_QRD,
        M_QOUT,
        M_EMIT
    } main_state_t;

endpackage
`default_nettype wire

### design/gab_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module gab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### design/gab_search.sv
// Binary search sequencer over the node id memory.
`timescale 1ns / 1ps
`default_nettype none
module gab_search import gab_pkg::*; #(
    parameter int MAX_NODES = 65536
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [63:0]                    key,
    input  wire logic [$clog2(MAX_NODES+1)-1:0] count,
    output logic                                ram_en,
    output logic      [$clog2(MAX_NODES)-1:0]   ram_addr,
    input  wire logic [63:0]                    ram_rdata,
    output search_ctl_t                         ctl,
    output logic      [$clog2(MAX_NODES)-1:0]   idx
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int BW = CW + 1;

    search_state_t         state_reg, state_next;
    logic signed [BW-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0]         mid_reg, mid_next;
    logic [63:0]           key_reg, key_next;
    logic [BW:0]           sum;
    logic signed [BW-1:0]  mid_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            key_reg   <= key_next;
        end
    end

    assign sum     = {lo_reg[BW-1], lo_reg} + {hi_reg[BW-1], hi_reg};
    assign mid_ext = $signed(BW'(mid_reg));
    assign idx     = mid_reg;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        ram_en     = 1'b0;
        ram_addr   = sum[IW:1];
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next    = '0;
                    hi_next    = $signed({1'b0, count}) - BW'(1);
                    key_next   = key;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    ctl.done   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_en     = 1'b1;
                    mid_next   = sum[IW:1];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    ctl.done   = 1'b1;
                    ctl.hit    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (ram_rdata < key_reg)
                    begin
                        lo_next = mid_ext + BW'(1);
                    end
                    else
                    begin
                        hi_next = mid_ext - BW'(1);
                    end
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### design/graph_adjacency_builder.sv
// Top level of the graph adjacency builder.
`timescale 1ns / 1ps
`default_nettype none
`include "graph_adjacency_builder_assert.svh"
// Builds adjacency lists from loaded node ids and way node sequences, one word at a
// time. Ids, successor counts and successor lists live in three single-port RAMs. A
// load writes the id and a zero count. A way start or way node runs a binary search
// over the id RAM, one read and compare per probe; a way node that differs from the
// last one then scans the successor list of each direction it links (forward only on
// a one-way way), one entry at a time. A query reads the node's count, then emits one
// result per successor. Results leave through an output register, so the next word
// is taken while a result waits. No clearing pass is needed: counts are zeroed on load.
module graph_adjacency_builder import gab_pkg::*; #(
    parameter int MAX_NODES = 65536,
    parameter int MAX_SUCC  = 9
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_ready,
    input  wire in_t  item,
    output logic      result_valid,
    input  wire logic result_ready,
    output out_t      result
);
    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int SW  = $clog2(MAX_SUCC + 1);
    localparam int SAW = $clog2(MAX_NODES * MAX_SUCC);

    main_state_t   state_reg, state_next;
    in_t           item_reg, item_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic [IW-1:0] origin_reg, origin_next;
    logic          origin_valid_reg, origin_valid_next;
    logic          oneway_reg, oneway_next;
    logic [19:0]   edge_reg, edge_next;
    logic [IW-1:0] from_reg, from_next, to_reg, to_next;
    logic          dir_reg, dir_next;
    logic [SW-1:0] n_reg, n_next, i_reg, i_next;
    logic [1:0]    added_reg, added_next;
    logic [1:0]    stat_reg, stat_next;
    out_t          res_reg, res_next;
    out_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic           id_en, id_we, s_en;
    logic [IW-1:0]  id_addr, s_addr;
    logic [63:0]    id_rdata;
    logic           c_en, c_we;
    logic [IW-1:0]  c_addr;
    logic [SW-1:0]  c_wdata, c_rdata, c_lim;
    logic           sc_en, sc_we;
    logic [SAW-1:0] sc_addr, base;
    logic [IW-1:0]  sc_wdata, sc_rdata;
    logic           s_start, dir_done, out_free;
    search_ctl_t    s_ctl;
    logic [IW-1:0]  s_idx;

    gab_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_id_ram (
        .clk(clk), .en(id_en), .we(id_we), .addr(id_addr),
        .wdata(item_reg.node_id), .rdata(id_rdata)
    );

    gab_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_count_ram (
        .clk(clk), .en(c_en), .we(c_we), .addr(c_addr),
        .wdata(c_wdata), .rdata(c_rdata)
    );

    gab_ram #(.WIDTH(IW), .DEPTH(MAX_NODES * MAX_SUCC)) u_succ_ram (
        .clk(clk), .en(sc_en), .we(sc_we), .addr(sc_addr),
        .wdata(sc_wdata), .rdata(sc_rdata)
    );

    gab_search #(.MAX_NODES(MAX_NODES)) u_search (
        .clk(clk), .rst_n(rst_n), .start(s_start), .key(item_reg.node_id),
        .count(lc_reg), .ram_en(s_en), .ram_addr(s_addr), .ram_rdata(id_rdata),
        .ctl(s_ctl), .idx(s_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= M_IDLE;
            item_reg         <= '0;
            lc_reg           <= '0;
            origin_reg       <= '0;
            origin_valid_reg <= 1'b0;
            oneway_reg       <= 1'b0;
            edge_reg         <= '0;
            from_reg         <= '0;
            to_reg           <= '0;
            dir_reg          <= 1'b0;
            n_reg            <= '0;
            i_reg            <= '0;
            added_reg        <= '0;
            stat_reg         <= '0;
            res_reg          <= '0;
            out_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            lc_reg           <= lc_next;
            origin_reg       <= origin_next;
            origin_valid_reg <= origin_valid_next;
            oneway_reg       <= oneway_next;
            edge_reg         <= edge_next;
            from_reg         <= from_next;
            to_reg           <= to_next;
            dir_reg          <= dir_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            added_reg        <= added_next;
            stat_reg         <= stat_next;
            res_reg          <= res_next;
            out_reg          <= out_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == M_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || result_ready;
    assign base         = SAW'(SAW'(from_reg) * SAW'(MAX_SUCC));
    assign c_lim        = (c_rdata > SW'(MAX_SUCC)) ? SW'(MAX_SUCC) : c_rdata;

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        lc_next           = lc_reg;
        origin_next       = origin_reg;
        origin_valid_next = origin_valid_reg;
        oneway_next       = oneway_reg;
        edge_next         = edge_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        dir_next          = dir_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        added_next        = added_reg;
        stat_next         = stat_reg;
        res_next          = res_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !result_ready;
        id_en             = 1'b0;
        id_we             = 1'b0;
        id_addr           = IW'(lc_reg);
        c_en              = 1'b0;
        c_we              = 1'b0;
        c_addr            = from_reg;
        c_wdata           = '0;
        sc_en             = 1'b0;
        sc_we             = 1'b0;
        sc_addr           = base + SAW'(i_reg);
        sc_wdata          = to_reg;
        s_start           = 1'b0;
        dir_done          = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = M_DISPATCH;
                end
            end
            M_DISPATCH:
            begin
                res_next   = '0;
                res_next.last = 1'b1;
                added_next = '0;
                stat_next  = STATUS_OK;
                dir_next   = 1'b0;
                unique case (item_reg.mode)
                    MODE_LOAD:
                    begin
                        if (lc_reg == CW'(MAX_NODES))
                        begin
                            res_next.status = STATUS_NODE_FULL;
                        end
                        else
                        begin
                            id_en   = 1'b1;
                            id_we   = 1'b1;
                            c_en    = 1'b1;
                            c_we    = 1'b1;
                            c_addr  = IW'(lc_reg);
                            lc_next = lc_reg + CW'(1);
                            res_next.node_index = 16'(lc_reg);
                        end
                        state_next = M_EMIT;
                    end
                    MODE_START, MODE_NEXT:
                    begin
                        s_start    = 1'b1;
                        state_next = M_SEARCH;
                    end
                    MODE_QUERY:
                    begin
                        res_next.node_index = item_reg.query_index;
                        from_next = IW'(item_reg.query_index);
                        if (32'(item_reg.query_index) >= 32'(lc_reg))
                        begin
                            res_next.status = STATUS_NOT_FOUND;
                            state_next      = M_EMIT;
                        end
                        else
                        begin
                            c_en       = 1'b1;
                            c_addr     = IW'(item_reg.query_index);
                            state_next = M_QCNT;
                        end
                    end
                    default:
                    begin
                        state_next = M_EMIT;
                    end
                endcase
            end
            M_SEARCH:
            begin
                id_en   = s_en;
                id_addr = s_addr;
                if (s_ctl.done)
                begin
                    if (item_reg.mode == MODE_START)
                    begin
                        oneway_next = item_reg.one_way;
                    end
                    if (!s_ctl.hit)
                    begin
                        origin_valid_next = 1'b0;
                        res_next.status   = STATUS_NOT_FOUND;
                        state_next        = M_EMIT;
                    end
                    else
                    begin
                        res_next.node_index = 16'(s_idx);
                        if (item_reg.mode == MODE_NEXT && origin_valid_reg
                            && origin_reg != s_idx)
                        begin
                            from_next  = origin_reg;
                            to_next    = s_idx;
                            state_next = M_ECNT;
                        end
                        else
                        begin
                            origin_next       = s_idx;
                            origin_valid_next = 1'b1;
                            state_next        = M_EMIT;
                        end
                    end
                end
            end
            M_ECNT:
            begin
                c_en       = 1'b1;
                state_next = M_ECNTW;
            end
            M_ECNTW:
            begin
                n_next     = c_lim;
                i_next     = '0;
                state_next = M_ESCAN;
            end
            M_ESCAN:
            begin
                if (i_reg < n_reg)
                begin
                    sc_en      = 1'b1;
                    state_next = M_ECMP;
                end
                else if (n_reg >= SW'(MAX_SUCC))
                begin
                    stat_next = STATUS_LIST_FULL;
                    dir_done  = 1'b1;
                end
                else
                begin
                    sc_en      = 1'b1;
                    sc_we      = 1'b1;
                    sc_addr    = base + SAW'(n_reg);
                    c_en       = 1'b1;
                    c_we       = 1'b1;
                    c_wdata    = n_reg + SW'(1);
                    added_next = added_reg + 2'd1;
                    if (edge_reg != EDGE_MAX)
                    begin
                        edge_next = edge_reg + 20'd1;
                    end
                    dir_done = 1'b1;
                end
            end
            M_ECMP:
            begin
                if (sc_rdata == to_reg)
                begin
                    dir_done = 1'b1;
                end
                else
                begin
                    i_next     = i_reg + SW'(1);
                    state_next = M_ESCAN;
                end
            end
            M_QCNT:
            begin
                n_next = c_lim;
                i_next = '0;
                if (c_lim == '0)
                begin
                    state_next = M_EMIT;
                end
                else
                begin
                    state_next = M_QRD;
                end
            end
            M_QRD:
            begin
                sc_en      = 1'b1;
                state_next = M_QOUT;
            end
            M_QOUT:
            begin
                if (out_free)
                begin
                    out_next             = res_reg;
                    out_next.total_edges = edge_reg;
                    out_next.succ_count  = 4'(n_reg);
                    out_next.succ_index  = 16'(sc_rdata);
                    out_next.last        = (i_reg + SW'(1) == n_reg);
                    out_valid_next       = 1'b1;
                    i_next               = i_reg + SW'(1);
                    state_next = (i_reg + SW'(1) == n_reg) ? M_IDLE : M_QRD;
                end
            end
            M_EMIT:
            begin
                if (out_free)
                begin
                    out_next             = res_reg;
                    out_next.total_edges = edge_reg;
                    out_valid_next       = 1'b1;
                    state_next           = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase

        if (dir_done)
        begin
            if (!dir_reg && !oneway_reg)
            begin
                dir_next   = 1'b1;
                from_next  = to_reg;
                to_next    = from_reg;
                state_next = M_ECNT;
            end
            else
            begin
                origin_next          = dir_reg ? from_reg : to_reg;
                origin_valid_next    = 1'b1;
                res_next.status      = (state_reg == M_ESCAN && n_reg >= SW'(MAX_SUCC)
                                        && i_reg >= n_reg) ? STATUS_LIST_FULL : stat_reg;
                res_next.edges_added = added_next;
                state_next           = M_EMIT;
            end
        end
    end

    `GAB_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
        "Builder took a word while another was in progress.")
    `GAB_ALWAYS(a_loaded_bound, lc_reg <= CW'(MAX_NODES),
        "Loaded node count passed the table depth.")
    `GAB_ALWAYS(a_search_owner, !s_ctl.done || state_reg == M_SEARCH,
        "Search finished outside the search state.")
    `GAB_NEXT(a_edges_monotonic, 1'b1, edge_reg >= $past(edge_reg),
        "Edge total decreased.")
endmodule
`default_nettype wire
